/* rtl/sll_pkg.sv */
// Shared types, constants and helpers for the static linked list block.
package sll_pkg;

  localparam int MAX_NODES = 64;
  localparam int SLOT_W = 7;
  localparam int ADDR_W = 6;
  localparam int POS_W = 8;
  localparam int DATA_W = 32;
  localparam int KIND_W = 2;

  localparam logic [SLOT_W-1:0] CAP_RESET = SLOT_W'(MAX_NODES);

  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_GET    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DELETE = 2'd2;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd3;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [POS_W-1:0]  pos;
    logic [DATA_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic              ok;
    logic [DATA_W-1:0] value_out;
    logic [SLOT_W-1:0] length;
  } out_word_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;
    logic clear_list;
    logic scan_step;
    logic take_slot;
    logic walk_step;
    logic fetch_obj;
    logic finish_get;
    logic unlink;
    logic link_new;
    logic link_prev;
    logic post;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              can_insert;
    logic              pos_ok;
    logic              scan_end;
    logic              scan_free;
    logic              walk_more;
    logic              out_busy;
  } status_t;

  // Slots are numbered from 1; memories are indexed from 0.
  function automatic logic [ADDR_W-1:0] slot_addr(input logic [SLOT_W-1:0] slot);
    logic [SLOT_W-1:0] t;
    t = slot - SLOT_W'(1);
    return t[ADDR_W-1:0];
  endfunction

endpackage

/* rtl/sll_datapath.sv */
// Datapath of the static linked list: slot stores, walk registers and result register.
module sll_datapath import sll_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [SLOT_W-1:0] cfg_wdata,
  input  in_word_t          in_word,
  input  cmd_t              cmd,
  output status_t           status,
  output logic              out_valid,
  input  logic              out_ready,
  output out_word_t         out_word
);

  logic [SLOT_W-1:0]    cap_reg;
  logic [SLOT_W-1:0]    cap;
  in_word_t             item;
  logic [MAX_NODES-1:0] used;
  logic [SLOT_W-1:0]    header;
  logic [SLOT_W-1:0]    count;
  logic [SLOT_W-1:0]    idx;
  logic [POS_W-1:0]     step;
  logic [SLOT_W-1:0]    cur;
  logic [SLOT_W-1:0]    slot;
  logic [SLOT_W-1:0]    obj;
  logic                 res_ok;
  logic [DATA_W-1:0]    res_val;
  logic [SLOT_W-1:0]    nxt;

  logic [SLOT_W-1:0]    link_mem [MAX_NODES];
  logic [DATA_W-1:0]    pay_mem  [MAX_NODES];
  logic [SLOT_W-1:0]    link_rdata;
  logic [DATA_W-1:0]    pay_rdata;
  logic                 link_we;
  logic [ADDR_W-1:0]    link_waddr;
  logic [SLOT_W-1:0]    link_wdata;

  assign cap = (cap_reg > SLOT_W'(MAX_NODES)) ? SLOT_W'(MAX_NODES) : cap_reg;
  // Link of the current slot: the header for slot 0, else the last link read.
  assign nxt = (cur == '0) ? header : link_rdata;

  assign status.kind       = item.kind;
  assign status.can_insert = count < cap;
  assign status.pos_ok     = item.pos < POS_W'(count);
  assign status.scan_end   = idx > cap;
  assign status.scan_free  = !used[slot_addr(idx)];
  assign status.walk_more  = (step < item.pos) && (nxt != '0);
  assign status.out_busy   = out_valid && !out_ready;

  always_comb begin
    link_we    = 1'b0;
    link_waddr = slot_addr(cur);
    link_wdata = slot;
    if (cmd.link_new) begin
      link_we    = 1'b1;
      link_waddr = slot_addr(slot);
      link_wdata = nxt;
    end else if (cmd.link_prev && cur != '0) begin
      link_we = 1'b1;
    end else if (cmd.unlink && cur != '0) begin
      link_we    = 1'b1;
      link_wdata = link_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    if (cmd.walk_step || cmd.fetch_obj) begin
      link_rdata <= link_mem[slot_addr(nxt)];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.link_new) begin
      pay_mem[slot_addr(slot)] <= item.value;
    end
    if (cmd.fetch_obj) begin
      pay_rdata <= pay_mem[slot_addr(nxt)];
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cap_reg   <= CAP_RESET;
      used      <= '0;
      header    <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        cap_reg <= cfg_wdata;
      end
      if (cmd.clear_list) begin
        used   <= '0;
        header <= '0;
        count  <= '0;
      end
      if (cmd.link_prev) begin
        used[slot_addr(slot)] <= 1'b1;
        count <= count + SLOT_W'(1);
        if (cur == '0) begin
          header <= slot;
        end
      end
      if (cmd.unlink) begin
        used[slot_addr(obj)] <= 1'b0;
        count <= count - SLOT_W'(1);
        if (cur == '0) begin
          header <= link_rdata;
        end
      end
      if (cmd.post) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload and walk registers.
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item    <= in_word;
      idx     <= SLOT_W'(1);
      step    <= '0;
      cur     <= '0;
      res_ok  <= 1'b0;
      res_val <= '0;
    end
    if (cmd.scan_step) begin
      idx <= idx + SLOT_W'(1);
    end
    if (cmd.take_slot) begin
      slot <= idx;
    end
    if (cmd.walk_step) begin
      cur  <= nxt;
      step <= step + POS_W'(1);
    end
    if (cmd.fetch_obj) begin
      obj <= nxt;
    end
    if (cmd.clear_list || cmd.link_prev) begin
      res_ok <= 1'b1;
    end
    if (cmd.finish_get || cmd.unlink) begin
      res_ok  <= 1'b1;
      res_val <= pay_rdata;
    end
    if (cmd.post) begin
      out_word.ok        <= res_ok;
      out_word.value_out <= res_val;
      out_word.length    <= count;
    end
  end

  a_count_matches_used: assert property (@(posedge clk) disable iff (rst)
    $countones(used) == int'(count))
    else $error("entry count differs from the number of used slots");

  a_header_empty: assert property (@(posedge clk) disable iff (rst)
    (count == '0) == (header == '0))
    else $error("header link disagrees with the entry count");

  a_post_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.post |-> !status.out_busy)
    else $error("result posted over a word not yet taken");

  a_insert_counts: assert property (@(posedge clk) disable iff (rst)
    cmd.link_prev |=> count == $past(count) + SLOT_W'(1))
    else $error("insert did not raise the entry count");

endmodule

/* rtl/sll_controller.sv */
// Controller state machine of the static linked list.
module sll_controller import sll_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  localparam logic [3:0] ST_IDLE      = 4'd0;
  localparam logic [3:0] ST_DECODE    = 4'd1;
  localparam logic [3:0] ST_SCAN      = 4'd2;
  localparam logic [3:0] ST_WALK      = 4'd3;
  localparam logic [3:0] ST_FETCH     = 4'd4;
  localparam logic [3:0] ST_FINISH    = 4'd5;
  localparam logic [3:0] ST_LINK_NEW  = 4'd6;
  localparam logic [3:0] ST_LINK_PREV = 4'd7;
  localparam logic [3:0] ST_DONE      = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = ST_DECODE;
        end
      end
      ST_DECODE: begin
        unique case (status.kind)
          KIND_INSERT: state_next = status.can_insert ? ST_SCAN : ST_DONE;
          KIND_GET, KIND_DELETE: state_next = status.pos_ok ? ST_WALK : ST_DONE;
          default: begin
            cmd.clear_list = 1'b1;
            state_next     = ST_DONE;
          end
        endcase
      end
      ST_SCAN: begin
        priority if (status.scan_end) begin
          state_next = ST_DONE;
        end else if (status.scan_free) begin
          cmd.take_slot = 1'b1;
          state_next    = ST_WALK;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      ST_WALK: begin
        priority if (status.walk_more) begin
          cmd.walk_step = 1'b1;
        end else if (status.kind == KIND_INSERT) begin
          state_next = ST_LINK_NEW;
        end else begin
          state_next = ST_FETCH;
        end
      end
      ST_FETCH: begin
        cmd.fetch_obj = 1'b1;
        state_next    = ST_FINISH;
      end
      ST_FINISH: begin
        if (status.kind == KIND_DELETE) begin
          cmd.unlink = 1'b1;
        end else begin
          cmd.finish_get = 1'b1;
        end
        state_next = ST_DONE;
      end
      ST_LINK_NEW: begin
        cmd.link_new = 1'b1;
        state_next   = ST_LINK_PREV;
      end
      ST_LINK_PREV: begin
        cmd.link_prev = 1'b1;
        state_next    = ST_DONE;
      end
      ST_DONE: begin
        if (!status.out_busy) begin
          cmd.post   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> state == ST_DECODE)
    else $error("accepted word did not start an operation");

  a_post_returns_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.post |=> in_ready)
    else $error("controller not idle after posting a result");

  a_one_write_phase: assert property (@(posedge clk) disable iff (rst)
    cmd.link_new |=> cmd.link_prev)
    else $error("insert link sequence broken");

endmodule

/* rtl/static_linked_list.sv */
// Top level of the static linked list: controller and datapath joined by command and status.
//
// The block keeps an ordered list of 32-bit words in a pool of 64 slots chained by
// next links, with a header link that points at the first entry. Each input word asks
// for one operation (insert, get, delete or clear) and produces exactly one result word
// carrying ok, the payload read or removed, and the length after the operation. One
// operation is in flight at a time. An insert first scans the used-slot bits one slot
// per cycle for the lowest free slot within the capacity, then walks the links one
// step per cycle, then relinks the new slot and its predecessor. The walk rate is set
// by the single read port of the link memory, whose read data is registered. The finished
// result sits in an output register, so a new word is accepted while the previous
// result waits to be taken. The capacity register (reset 64, values above 64 act as 64)
// limits the free-slot search and the full test; it should be written only while the
// block is idle.
module static_linked_list import sll_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [SLOT_W-1:0] cfg_wdata,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_word_t          in_word,
  output logic              out_valid,
  input  logic              out_ready,
  output out_word_t         out_word
);

  cmd_t    cmd;
  status_t status;

  // The controller sequences each operation through its scan, walk, fetch and relink phases.
  sll_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // The datapath holds the link and payload memories, used bits and the result word.
  sll_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_word   (in_word),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

endmodule
